FILE: rtl/glr_pkg.sv
// G-code line receiver package: character codes, verdict codes, result
// record and the streaming decimal-number parser step.
// No dependencies.
package glr_pkg;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic [31:0] STR_M110 = 32'h4D313130;
	localparam logic [31:0] STR_M108 = 32'h4D313038;
	localparam logic [31:0] STR_M112 = 32'h4D313132;
	localparam logic [31:0] STR_M410 = 32'h4D343130;

	localparam logic [0:0] KIND_ECHO    = 1'b0;
	localparam logic [0:0] KIND_VERDICT = 1'b1;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_SEQ    = 3'd1;
	localparam logic [2:0] ST_CSUM   = 3'd2;
	localparam logic [2:0] ST_NOCSUM = 3'd3;
	localparam logic [2:0] ST_NONUM  = 3'd4;

	localparam logic [1:0] EM_NONE = 2'd0;
	localparam logic [1:0] EM_M108 = 2'd1;
	localparam logic [1:0] EM_M112 = 2'd2;
	localparam logic [1:0] EM_M410 = 2'd3;

	// number parser phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_SKIP  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	typedef struct packed {
		logic [1:0]  phase;
		logic        neg;
		logic [31:0] mag;
	} parse_t;

	typedef struct packed {
		logic               result_kind;
		logic [7:0]         char_value;
		logic [6:0]         char_index;
		logic [2:0]         verdict_status;
		logic signed [31:0] line_number;
		logic [7:0]         computed_checksum;
		logic [6:0]         line_length;
		logic               m110_seen;
		logic [1:0]         emergency_code;
		logic               stopped_motion_alert;
	} result_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// one byte through a running parser; saturates at the signed 32-bit limits
	function automatic parse_t parse_step(input parse_t p, input logic [7:0] c);
		parse_t      n;
		logic [35:0] acc;
		logic [35:0] lim;
		logic [31:0] sat;
		logic        is_dig;
		n      = p;
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		acc    = ({4'b0, p.mag} << 3) + ({4'b0, p.mag} << 1) + {32'b0, c[3:0]};
		lim    = p.neg ? 36'h080000000 : 36'h07FFFFFFF;
		sat    = (acc > lim) ? lim[31:0] : acc[31:0];
		unique case (p.phase)
			PH_SKIP: begin
				if (is_blank(c)) begin
					n = p;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					n.phase = PH_DIGIT;
					n.neg   = (c == CH_MINUS);
				end else if (is_dig) begin
					n.phase = PH_DIGIT;
					n.mag   = sat;
				end else begin
					n.phase = PH_DONE;
				end
			end
			PH_DIGIT: begin
				if (is_dig) n.mag = sat;
				else n.phase = PH_DONE;
			end
			PH_IDLE, PH_DONE: n = p;
			default: n = p;
		endcase
		return n;
	endfunction

	function automatic logic [31:0] parse_value(input parse_t p);
		return p.neg ? (~p.mag + 32'd1) : p.mag;
	endfunction

endpackage

FILE: rtl/glr_if.sv
// Stream interfaces of the G-code line receiver: host byte channel and
// result channel. Depends on glr_pkg for the result record.
interface glr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       machine_stopped;
	modport source (output valid, output rx_byte, output machine_stopped, input ready);
	modport sink (input valid, input rx_byte, input machine_stopped, output ready);
endinterface

interface glr_res_if;
	logic             valid;
	logic             ready;
	glr_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/gcode_line_receiver.sv
// G-code line receiver top level.
// Depends on glr_pkg and the interfaces in glr_if.sv.
//
// Usage:
//   rx  : host bytes, one per transfer, with the machine_stopped flag.
//   res : results. A stored byte gives an echo (kind 0) with its index in
//         the line; an unescaped CR/LF closing a non-empty line gives a
//         verdict (kind 1): sequence and checksum status, line number,
//         checksum, length, M110 flag, emergency code and motion alert.
//   Bytes that open or sit in a comment, backslashes, overflow bytes and
//   empty line ends give no result.
// Each result is registered before it appears on res.
// Throughput: one byte per cycle while the skid register is free. All
//   line analysis runs on the fly in running accumulators (checksum,
//   four number parsers, last-four-bytes window), so the verdict is ready
//   on the line-end byte itself and no line buffer is read back.
// Stall: results sit in an output register backed by a one-entry skid
//   register; rx.ready drops only while the skid register is occupied.
// Reset: line state and last line number (zero) are cleared and both result
//   registers are emptied; rx is ready in the first cycle after reset.
module gcode_line_receiver #(
	parameter int LINE_CAPACITY = 96
) (
	input  logic                clk,
	input  logic                arst_n,
	glr_rx_if.sink              rx,
	glr_res_if.source           res
);
	import glr_pkg::*;

	localparam int CW = $clog2(LINE_CAPACITY);
	localparam logic [CW-1:0] CNT_LAST = CW'(LINE_CAPACITY - 1);

	logic [CW-1:0] cnt_q, cnt_d;
	logic          esc_q, esc_d;
	logic          comment_q, comment_d;
	logic          lead_q, lead_d;
	logic          has_n_q, has_n_d;
	logic [2:0]    kc_q, kc_d;
	logic [7:0]    sum_q, sum_d;
	logic [31:0]   recent_q, recent_d;
	logic          m110_q, m110_d;
	parse_t        p1_q, p1_d, p2_q, p2_d, p3_q, p3_d, p4_q, p4_d;
	logic [31:0]   last_q, last_d;

	result_t main_q, skid_q, new_res;
	logic    out_v_q, skid_v_q;

	logic          in_acc, store_en, line_end, push, pop;
	logic [7:0]    c;
	logic          full, nonlead, first_nonlead;
	logic [31:0]   window;
	logic [CW+6:0] idx_ext;
	logic [31:0]   num;
	logic [2:0]    status;
	logic          csum_ok, has_star;

	assign in_acc   = rx.valid && rx.ready;
	assign rx.ready = !skid_v_q;
	assign c        = rx.rx_byte;
	assign full     = (cnt_q == CNT_LAST);
	assign idx_ext  = {7'b0, cnt_q};
	assign pop      = out_v_q && res.ready;
	assign res.valid = out_v_q;
	assign res.data  = main_q;

	assign nonlead       = !lead_q || (c != CH_SPACE);
	assign first_nonlead = lead_q && (c != CH_SPACE);
	assign window        = {recent_q[23:0], c};
	assign has_star      = (p3_q.phase != PH_IDLE);

	// verdict terms from the accumulated line state
	always_comb begin
		num = 32'd0;
		if (has_n_q) begin
			if (m110_q && p2_q.phase != PH_IDLE) num = parse_value(p2_q);
			else num = parse_value(p1_q);
		end
		csum_ok = (p3_q.mag == {24'b0, sum_q}) && (!p3_q.neg || p3_q.mag == 32'd0);
		status = ST_OK;
		if (has_n_q) begin
			if (num != last_q + 32'd1 && !m110_q) status = ST_SEQ;
			else if (!has_star) status = ST_NOCSUM;
			else if (!csum_ok) status = ST_CSUM;
		end else if (has_star) begin
			status = ST_NONUM;
		end
	end

	always_comb begin
		cnt_d     = cnt_q;
		esc_d     = esc_q;
		comment_d = comment_q;
		lead_d    = lead_q;
		has_n_d   = has_n_q;
		kc_d      = kc_q;
		sum_d     = sum_q;
		recent_d  = recent_q;
		m110_d    = m110_q;
		p1_d      = p1_q;
		p2_d      = p2_q;
		p3_d      = p3_q;
		p4_d      = p4_q;
		last_d    = last_q;
		store_en  = 1'b0;
		line_end  = 1'b0;
		new_res   = '0;
		push      = 1'b0;

		if (esc_q) begin
			esc_d    = 1'b0;
			store_en = !comment_q && !full;
		end else if (c == CH_LF || c == CH_CR) begin
			line_end  = 1'b1;
			comment_d = 1'b0;
		end else if (full) begin
			store_en = 1'b0;
		end else if (c == CH_BSLASH) begin
			esc_d = 1'b1;
		end else begin
			if (c == CH_SEMI) comment_d = 1'b1;
			store_en = !comment_q && (c != CH_SEMI);
		end

		if (in_acc && store_en) begin
			push               = 1'b1;
			new_res.result_kind = KIND_ECHO;
			new_res.char_value  = c;
			new_res.char_index  = idx_ext[6:0];
			cnt_d    = cnt_q + CW'(1);
			lead_d   = lead_q && (c == CH_SPACE);
			if (first_nonlead) has_n_d = (c == CH_N);
			if (nonlead && kc_q < 3'd5) kc_d = kc_q + 3'd1;
			if (nonlead && !has_star && c != CH_STAR) sum_d = sum_q ^ c;
			recent_d = window;
			if (window == STR_M110) m110_d = 1'b1;
			if (p1_q.phase == PH_IDLE) begin
				if (first_nonlead && c == CH_N) p1_d.phase = PH_SKIP;
			end else p1_d = parse_step(p1_q, c);
			if (p2_q.phase == PH_IDLE) begin
				if (nonlead && kc_q >= 3'd4 && c == CH_N) p2_d.phase = PH_SKIP;
			end else p2_d = parse_step(p2_q, c);
			if (p3_q.phase == PH_IDLE) begin
				if (c == CH_STAR) p3_d.phase = PH_SKIP;
			end else p3_d = parse_step(p3_q, c);
			if (p4_q.phase == PH_IDLE) begin
				if (c == CH_G) p4_d.phase = PH_SKIP;
			end else p4_d = parse_step(p4_q, c);
		end

		if (in_acc && line_end) begin
			if (cnt_q != '0) begin
				push                      = 1'b1;
				new_res.result_kind       = KIND_VERDICT;
				new_res.verdict_status    = status;
				new_res.line_number       = num;
				new_res.computed_checksum = sum_q;
				new_res.line_length       = idx_ext[6:0];
				new_res.m110_seen         = m110_q;
				if (status == ST_OK) begin
					if (has_n_q) last_d = num;
					new_res.stopped_motion_alert = rx.machine_stopped
						&& (p4_q.phase != PH_IDLE) && (p4_q.mag <= 32'd3)
						&& (!p4_q.neg || p4_q.mag == 32'd0);
					if (kc_q == 3'd4) begin
						case (recent_q)
							STR_M108: new_res.emergency_code = EM_M108;
							STR_M112: new_res.emergency_code = EM_M112;
							STR_M410: new_res.emergency_code = EM_M410;
							default:  new_res.emergency_code = EM_NONE;
						endcase
					end
				end
			end
			cnt_d    = '0;
			lead_d   = 1'b1;
			has_n_d  = 1'b0;
			kc_d     = 3'd0;
			sum_d    = 8'd0;
			recent_d = 32'd0;
			m110_d   = 1'b0;
			p1_d     = '0;
			p2_d     = '0;
			p3_d     = '0;
			p4_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			esc_q     <= 1'b0;
			comment_q <= 1'b0;
			lead_q    <= 1'b1;
			has_n_q   <= 1'b0;
			kc_q      <= 3'd0;
			sum_q     <= 8'd0;
			recent_q  <= 32'd0;
			m110_q    <= 1'b0;
			p1_q      <= '0;
			p2_q      <= '0;
			p3_q      <= '0;
			p4_q      <= '0;
			last_q    <= 32'd0;
		end else if (in_acc) begin
			cnt_q     <= cnt_d;
			esc_q     <= esc_d;
			comment_q <= comment_d;
			lead_q    <= lead_d;
			has_n_q   <= has_n_d;
			kc_q      <= kc_d;
			sum_q     <= sum_d;
			recent_q  <= recent_d;
			m110_q    <= m110_d;
			p1_q      <= p1_d;
			p2_q      <= p2_d;
			p3_q      <= p3_d;
			p4_q      <= p4_d;
			last_q    <= last_d;
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_v_q || pop) out_v_q <= 1'b1;
				else skid_v_q <= 1'b1;
			end else if (pop) begin
				if (skid_v_q) skid_v_q <= 1'b0;
				else out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_v_q || pop) main_q <= new_res;
			else skid_q <= new_res;
		end else if (pop && skid_v_q) begin
			main_q <= skid_q;
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without a result in the output register");

	a_echo_counts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && store_en |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("stored byte did not advance the line count");

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && line_end |=> cnt_q == '0 && !comment_q)
		else $error("line end left line state behind");

endmodule

FILE: verif/tb.sv
// Self-checking bench for gcode_line_receiver: line-builder stimulus over the
// rx stream, a byte-level line predictor in a scoreboard class, checks on res.
// Depends on rtl/glr_pkg.sv, rtl/glr_if.sv and rtl/gcode_line_receiver.sv.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import glr_pkg::*;

	localparam int CAP        = 96;
	localparam int BYTE_GOAL  = 1350;
	localparam int IDLE_LIMIT = 5000;

	class line_scoreboard;
		logic [7:0]  line_buf[CAP];
		logic [31:0] last_num;
		int          count;
		bit          in_comment;
		bit          esc_pending;
		result_t     pending_q[$];
		int          errors;
		int          echoes;
		int          verdicts;
		int          ok_lines;

		function new();
			last_num = '0; count = 0; in_comment = 0; esc_pending = 0;
			errors = 0; echoes = 0; verdicts = 0; ok_lines = 0;
		endfunction

		function bit blank(logic [7:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function longint parse_num(int p, int n);
			bit     neg;
			longint mag;
			longint lim;
			neg = 0; mag = 0;
			while (p < n && blank(line_buf[p])) p++;
			if (p < n && (line_buf[p] == CH_PLUS || line_buf[p] == CH_MINUS)) begin
				neg = line_buf[p] == CH_MINUS;
				p++;
			end
			lim = neg ? 64'd2147483648 : 64'd2147483647;
			while (p < n && line_buf[p] >= CH_ZERO && line_buf[p] <= CH_NINE) begin
				mag = mag * 10 + line_buf[p][3:0];
				if (mag > lim) mag = lim;
				p++;
			end
			return neg ? -mag : mag;
		endfunction

		function int find_byte(int from, int n, logic [7:0] c);
			for (int i = from; i < n; i++)
				if (line_buf[i] == c) return i;
			return n;
		endfunction

		function logic [31:0] word_at(int i);
			return {line_buf[i], line_buf[i+1], line_buf[i+2], line_buf[i+3]};
		endfunction

		function result_t close_line(bit stopped);
			result_t     r;
			int          n, s, star, np, g;
			bit          has_n, has_star, m110;
			logic [7:0]  sum;
			logic [2:0]  status;
			longint      num, v;
			n = count; s = 0; sum = 0; m110 = 0; num = 0; status = ST_OK;
			r = '0;
			while (s < n && line_buf[s] == CH_SPACE) s++;
			has_n    = s < n && line_buf[s] == CH_N;
			star     = find_byte(s, n, CH_STAR);
			has_star = star < n;
			for (int i = s; i < star; i++) sum ^= line_buf[i];
			for (int i = s; i + 4 <= n; i++)
				if (word_at(i) == STR_M110) begin
					m110 = 1;
					break;
				end
			if (has_n) begin
				np = s;
				if (m110 && s + 4 < n) begin
					g = find_byte(s + 4, n, CH_N);
					if (g < n) np = g;
				end
				num = parse_num(np + 1, n);
				if (num[31:0] != last_num + 32'd1 && !m110) status = ST_SEQ;
				else if (!has_star) status = ST_NOCSUM;
				else if (parse_num(star + 1, n) != longint'(sum)) status = ST_CSUM;
				else last_num = num[31:0];
			end else if (has_star) begin
				status = ST_NONUM;
			end
			if (status == ST_OK) begin
				ok_lines++;
				if (stopped) begin
					g = find_byte(s, n, CH_G);
					if (g < n) begin
						v = parse_num(g + 1, n);
						if (v >= 0 && v <= 3) r.stopped_motion_alert = 1'b1;
					end
				end
				if (n - s == 4) begin
					if (word_at(s) == STR_M108) r.emergency_code = EM_M108;
					else if (word_at(s) == STR_M112) r.emergency_code = EM_M112;
					else if (word_at(s) == STR_M410) r.emergency_code = EM_M410;
				end
			end
			r.result_kind       = KIND_VERDICT;
			r.verdict_status    = status;
			r.line_number       = num[31:0];
			r.computed_checksum = sum;
			r.line_length       = n[6:0];
			r.m110_seen         = m110;
			return r;
		endfunction

		function void keep_byte(logic [7:0] c);
			result_t r;
			if (count >= CAP - 1) return;
			line_buf[count] = c;
			r = '0;
			r.result_kind = KIND_ECHO;
			r.char_value  = c;
			r.char_index  = count[6:0];
			count++;
			pending_q.push_back(r);
		endfunction

		// one accepted rx transfer
		function void note_input(logic [7:0] c, bit stopped);
			if (esc_pending) begin
				esc_pending = 0;
				if (!in_comment) keep_byte(c);
				return;
			end
			if (c == CH_LF || c == CH_CR) begin
				in_comment = 0;
				if (count == 0) return;
				pending_q.push_back(close_line(stopped));
				count = 0;
				return;
			end
			if (count >= CAP - 1) return;
			if (c == CH_BSLASH) begin
				esc_pending = 1;
				return;
			end
			if (c == CH_SEMI) in_comment = 1;
			if (!in_comment) keep_byte(c);
		endfunction

		task report(string what, longint got, longint want);
			$display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(result_t r);
			result_t e;
			if (pending_q.size() == 0) begin
				report("result with nothing pending", longint'(r.result_kind), 0);
				return;
			end
			e = pending_q.pop_front();
			if (r.result_kind == KIND_ECHO) echoes++; else verdicts++;
			if (r.result_kind != e.result_kind) report("result_kind", r.result_kind, e.result_kind);
			if (r.char_value != e.char_value) report("char_value", r.char_value, e.char_value);
			if (r.char_index != e.char_index) report("char_index", r.char_index, e.char_index);
			if (r.verdict_status != e.verdict_status)
				report("verdict_status", r.verdict_status, e.verdict_status);
			if (r.line_number != e.line_number)
				report("line_number", r.line_number, e.line_number);
			if (r.computed_checksum != e.computed_checksum)
				report("computed_checksum", r.computed_checksum, e.computed_checksum);
			if (r.line_length != e.line_length)
				report("line_length", r.line_length, e.line_length);
			if (r.m110_seen != e.m110_seen) report("m110_seen", r.m110_seen, e.m110_seen);
			if (r.emergency_code != e.emergency_code)
				report("emergency_code", r.emergency_code, e.emergency_code);
			if (r.stopped_motion_alert != e.stopped_motion_alert)
				report("stopped_motion_alert", r.stopped_motion_alert, e.stopped_motion_alert);
		endtask
	endclass

	logic clk;
	logic arst_n;
	glr_rx_if  rx();
	glr_res_if res();

	gcode_line_receiver #(.LINE_CAPACITY(CAP)) dut (
		.clk(clk), .arst_n(arst_n), .rx(rx), .res(res)
	);

	line_scoreboard sb = new();
	int sent_bytes = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_mode = 0;
	int cyc = 0;

	initial begin
		clk = 0;
		arst_n = 0;
		rx.valid = 0;
		rx.rx_byte = '0;
		rx.machine_stopped = 0;
		res.ready = 0;
	end

	always #4 clk = ~clk;

	// receiver stall pattern, switching at random among four styles
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: res.ready <= 1'b1;
			1: res.ready <= 1'($urandom_range(0, 1));
			2: res.ready <= (cyc % 16) < 11;
			default: res.ready <= $urandom_range(0, 7) != 0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) sb.check_result(res.data);
	end

	always @(posedge clk) begin
		if (!arst_n || (rx.valid && rx.ready) || (res.valid && res.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit stopped);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				rx.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		rx.machine_stopped <= stopped;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		sb.note_input(b, stopped);
		sent_bytes++;
	endtask

	task automatic send_text(input string s, input bit use_cr = 0);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'($urandom_range(0, 1)));
		send_byte(use_cr ? CH_CR : CH_LF, 1'($urandom_range(0, 1)));
	endtask

	// numbered command, with checksum unless fault is 3; fault picks the kind of damage
	task automatic send_numbered(input string cmd, input int fault);
		string       body;
		string       pad;
		logic [7:0]  cs;
		logic [31:0] ln;
		ln = sb.last_num + 32'd1;
		if (fault == 1) ln = ln + $urandom_range(1, 5);
		body = $sformatf("N%0d %s", $signed(ln), cmd);
		cs = 0;
		for (int i = 0; i < body.len(); i++) cs ^= body[i];
		if (fault == 2) cs ^= 8'($urandom_range(1, 255));
		pad = "";
		if ($urandom_range(0, 4) == 0) pad = "  ";
		if (fault == 3) send_text({pad, body}, 1'($urandom_range(0, 1)));
		else if ($urandom_range(0, 5) == 0)
			send_text({pad, body, $sformatf("*%0d ;note", cs)}, 1'($urandom_range(0, 1)));
		else send_text({pad, body, $sformatf("*%0d", cs)}, 1'($urandom_range(0, 1)));
	endtask

	function automatic string pick_cmd();
		case ($urandom_range(0, 9))
			0: return $sformatf("G%0d X%0d", $urandom_range(0, 5), $urandom_range(0, 999));
			1: return $sformatf("G%0d", $urandom_range(0, 3));
			2: return $sformatf("M110 N%0d", $urandom_range(0, 20));
			3: return $sformatf("M110 N-%0d", $urandom_range(0, 3));
			4: return "M105";
			5: return $sformatf("G1 F%0d E-%0d", $urandom_range(1, 9999), $urandom_range(0, 99));
			6: return "G28";
			7: return "M114";
			8: return $sformatf("G  +%0d Y9", $urandom_range(0, 4));
			default: return $sformatf("T%0d", $urandom_range(0, 3));
		endcase
	endfunction

	task automatic send_noise();
		int len;
		len = $urandom_range(0, 12);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_byte(CH_LF, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_overlong();
		int len;
		len = $urandom_range(CAP - 3, CAP + 8);
		for (int i = 0; i < len; i++) send_byte(8'($urandom_range(32, 126)), 0);
		send_byte(CH_BSLASH, 0);
		send_byte(CH_LF, 0);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty line, emergencies, sequence, M110 without line number, escape,
		// comment, zero byte, star without number, overflow
		send_byte(CH_CR, 0);
		send_text("M112");
		send_text(" M410", 1);
		send_numbered("M108", 0);
		send_numbered("G2", 1);
		send_text("M110 N-1*x");
		send_byte(8'h00, 1); send_byte(CH_BSLASH, 1); send_byte(CH_LF, 1);
		send_byte(CH_BSLASH, 0); send_byte(CH_SEMI, 0); send_byte(8'hFF, 0);
		send_byte(CH_LF, 1);
		send_text("G1;\\x");
		send_text("G0*0");
		send_text("N99999999999 G3");
		send_overlong();

		while (sent_bytes < BYTE_GOAL) begin
			case ($urandom_range(0, 19))
				0, 1:    send_noise();
				2:       send_text($urandom_range(0, 1) ? "M108" : "M112");
				3:       send_numbered(pick_cmd(), 2);
				4:       send_numbered(pick_cmd(), 1);
				5:       send_numbered(pick_cmd(), 3);
				6:       send_text({"N", pick_cmd(), "\\;q"});
				7:       if ($urandom_range(0, 5) == 0) send_overlong();
				         else send_text(pick_cmd());
				default: send_numbered(pick_cmd(), 0);
			endcase
		end
		rx.valid <= 1'b0;

		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("sent %0d bytes: %0d echoes and %0d line verdicts checked, %0d lines accepted",
			sent_bytes, sb.echoes, sb.verdicts, sb.ok_lines);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors, sb.pending_q.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
